// File: sv/fbpa_pkg.sv
// shared types and constants for the fixed block pool allocator
package fbpa_pkg;

  localparam int MaxBlocks = 256;
  localparam int IdxW      = 8;
  localparam int CntW      = 9;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_EMPTY        = 3'd1;
  localparam logic [2:0] ST_TOO_BIG      = 3'd2;
  localparam logic [2:0] ST_NOT_SET_UP   = 3'd3;
  localparam logic [2:0] ST_MISALIGNED   = 3'd4;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd5;
  localparam logic [2:0] ST_FULL         = 3'd6;
  localparam logic [2:0] ST_BAD_GEOMETRY = 3'd7;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_ENTRY = 2'd2;

  // request passed from the front part to the back part
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] request_size;
    logic [31:0] block_address;
  } req_t;

  // result produced by the back part
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [8:0]  entry_total;
  } res_t;

endpackage

// File: sv/fbpa_front.sv
// input stage and two-entry request queue
module fbpa_front import fbpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_take,
  output req_t q_req
);

  req_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_req    = slot[rd_ptr];

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) slot[wr_ptr] <= in_req;
  end

endmodule

// File: sv/fbpa_divider.sv
// iterative 32 by 25 bit unsigned divider, one quotient bit per cycle
module fbpa_divider import fbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [24:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [24:0] remainder
);

  logic [31:0] q;
  logic [25:0] r;
  logic [5:0]  steps;
  logic        busy;
  logic [25:0] trial;
  logic [25:0] shifted;

  assign shifted   = {r[24:0], q[31]};
  assign trial     = shifted - {1'b0, divisor};
  assign quotient  = q;
  assign remainder = r[24:0];

  // restoring division step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 6'd0;
        q     <= dividend;
        r     <= 26'd0;
      end else if (busy) begin
        if (!trial[25]) begin
          r <= trial;
          q <= {q[30:0], 1'b1};
        end else begin
          r <= shifted;
          q <= {q[30:0], 1'b0};
        end
        steps <= steps + 6'd1;
        if (steps == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/fbpa_back.sv
// back part: pool state, ring memory and request sequencer
module fbpa_back import fbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] region_start,
  input  logic [31:0] region_size,
  input  logic [24:0] requested_entry_size,
  input  logic        q_valid,
  output logic        q_take,
  input  req_t        q_req,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CHECK, S_FILL, S_READ, S_OUT
  } state_t;

  state_t      state;
  req_t        cur;
  logic [31:0] ring [MaxBlocks];
  logic [31:0] ring_rd;
  logic [IdxW-1:0] put_index;
  logic [IdxW-1:0] take_index;
  logic        ring_empty;
  logic [CntW-1:0] free_count;
  logic [CntW-1:0] block_count;
  logic [24:0] padded_size;
  logic [31:0] blocks_base;
  logic        pool_ready;
  logic [CntW-1:0] fill_i;
  logic [31:0] fill_addr;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [24:0] div_divisor;
  logic        div_done;
  logic [31:0] div_q;
  logic [24:0] div_r;

  logic [25:0] padded_w;
  logic [24:0] padded_c;
  logic        pad_bad;
  logic [IdxW-1:0] put_adv;
  logic [IdxW-1:0] take_adv;
  logic        ring_full;

  // entry size rounded up to a multiple of 64 bytes
  assign padded_w = {1'b0, requested_entry_size} + 26'h3F;
  assign padded_c = {padded_w[24:6], 6'd0};
  assign pad_bad  = padded_w[25] || (padded_c == 25'd0);

  assign put_adv  = ({1'b0, put_index} + 9'd1 >= block_count) ? '0 : put_index + 1'b1;
  assign take_adv = ({1'b0, take_index} + 9'd1 >= block_count) ? '0 : take_index + 1'b1;
  assign ring_full = !ring_empty && (take_index == put_index);

  assign q_take    = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  assign div_divisor = (cur.opcode == OP_INIT) ? padded_c : padded_size;

  fbpa_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // ring memory with registered read
  always_ff @(posedge clk) begin
    ring_rd <= ring[take_index];
    if (state == S_FILL) ring[put_index] <= fill_addr;
    else if (state == S_CHECK && cur.opcode == OP_FREE && pool_ready
             && div_r == 25'd0 && {1'b0, div_q} < {24'd0, block_count} && !ring_full)
      ring[put_index] <= cur.block_address;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      div_start   <= 1'b0;
      put_index   <= '0;
      take_index  <= '0;
      ring_empty  <= 1'b1;
      free_count  <= '0;
      block_count <= '0;
      padded_size <= '0;
      blocks_base <= '0;
      pool_ready  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_req;
            out_res.granted_address <= 32'd0;
            out_res.status <= ST_OK;
            out_res.entry_total <= free_count;
            case (q_req.opcode)
              OP_INIT: begin
                put_index   <= '0;
                take_index  <= '0;
                ring_empty  <= 1'b1;
                free_count  <= '0;
                block_count <= '0;
                padded_size <= '0;
                blocks_base <= '0;
                pool_ready  <= 1'b0;
                out_res.entry_total <= '0;
                if (pad_bad) begin
                  out_res.status <= ST_BAD_GEOMETRY;
                  state <= S_OUT;
                end else begin
                  div_dividend <= region_size;
                  div_start <= 1'b1;
                  state <= S_DIV;
                end
              end
              OP_ALLOC: begin
                if (!pool_ready) begin
                  out_res.status <= ST_NOT_SET_UP;
                  state <= S_OUT;
                end else if (q_req.request_size > {7'd0, padded_size}) begin
                  out_res.status <= ST_TOO_BIG;
                  state <= S_OUT;
                end else if (ring_empty) begin
                  out_res.status <= ST_EMPTY;
                  state <= S_OUT;
                end else begin
                  state <= S_READ;
                end
              end
              OP_FREE: begin
                if (!pool_ready) begin
                  out_res.status <= ST_NOT_SET_UP;
                  state <= S_OUT;
                end else begin
                  div_dividend <= q_req.block_address - blocks_base;
                  div_start <= 1'b1;
                  state <= S_DIV;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) state <= S_CHECK;
        end
        S_CHECK: begin
          if (cur.opcode == OP_INIT) begin
            if (div_q <= 32'd1 || {div_q, 2'b00} >= {9'd0, padded_c}
                || div_q - 32'd1 > 32'(MaxBlocks)) begin
              out_res.status <= ST_BAD_GEOMETRY;
              state <= S_OUT;
            end else begin
              padded_size <= padded_c;
              block_count <= CntW'(div_q - 32'd1);
              blocks_base <= region_start + {div_q[29:0], 2'b00};
              fill_addr   <= region_start + {div_q[29:0], 2'b00};
              fill_i      <= '0;
              state <= S_FILL;
            end
          end else begin
            if (div_r != 25'd0) out_res.status <= ST_MISALIGNED;
            else if ({1'b0, div_q} >= {24'd0, block_count}) out_res.status <= ST_OUT_OF_RANGE;
            else if (ring_full) out_res.status <= ST_FULL;
            else begin
              put_index  <= put_adv;
              free_count <= free_count + 1'b1;
              ring_empty <= 1'b0;
              out_res.entry_total <= free_count + 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_FILL: begin
          put_index  <= put_adv;
          free_count <= free_count + 1'b1;
          ring_empty <= 1'b0;
          fill_addr  <= fill_addr + {7'd0, padded_size};
          fill_i     <= fill_i + 1'b1;
          if (fill_i + 1'b1 == block_count) begin
            pool_ready <= 1'b1;
            out_res.entry_total <= block_count;
            state <= S_OUT;
          end
        end
        S_READ: begin
          state <= S_OUT;
          out_res.granted_address <= ring_rd;
          take_index <= take_adv;
          free_count <= free_count - 1'b1;
          if (free_count == 9'd1) ring_empty <= 1'b1;
          out_res.entry_total <= free_count - 1'b1;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/fixed_block_pool_fifo_allocator_core.sv
// top level of the fixed block pool allocator
// Usage: write region_start (0x0), region_size (0x4) and requested_entry_size
// (0x8) over the APB port while idle, then send an init request. Each request
// (opcode, request_size, block_address) enters on in_valid/in_stall and
// gives exactly one result (status, granted_address, entry_total) on
// out_valid/out_stall.
// A two-entry queue takes requests while the back part works or holds a result.
// Allocate passes from request accept through one ring memory read to out_valid;
// free runs the 32-step divider computing offset and alignment, then the checks;
// init runs the divider, then writes each block into the ring (up to 256).
// Failed checks that skip the divider go straight to the result.
// The back part works on one request at a time and takes the next one in the
// cycle after its result is accepted.
// Reset empties the queue, marks the pool not set up and restores the
// registers (entry size 64). The ring memory needs no clearing.
// While the receiver stalls, the result holds and the queue fills, then
// in_stall rises.
module fixed_block_pool_fifo_allocator_core import fbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] request_size,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] granted_address,
  output logic [8:0]  entry_total
);

  logic [31:0] region_start;
  logic [31:0] region_size;
  logic [24:0] requested_entry_size;
  logic [1:0]  reg_sel;
  req_t        in_req;
  req_t        q_req;
  logic        q_valid;
  logic        q_take;
  res_t        out_res;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start         <= 32'd0;
      region_size          <= 32'd0;
      requested_entry_size <= 25'd64;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_START: region_start <= pwdata;
        REG_SIZE:  region_size <= pwdata;
        REG_ENTRY: requested_entry_size <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_sel)
      REG_START: prdata = region_start;
      REG_SIZE:  prdata = region_size;
      REG_ENTRY: prdata = {7'd0, requested_entry_size};
      default:   prdata = 32'd0;
    endcase
  end

  assign in_req = '{opcode: opcode, request_size: request_size,
                    block_address: block_address};

  fbpa_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
  );

  fbpa_back u_back (
    .clk(clk), .rst(rst), .region_start(region_start), .region_size(region_size),
    .requested_entry_size(requested_entry_size), .q_valid(q_valid),
    .q_take(q_take), .q_req(q_req), .out_valid(out_valid),
    .out_stall(out_stall), .out_res(out_res)
  );

  assign status          = out_res.status;
  assign granted_address = out_res.granted_address;
  assign entry_total     = out_res.entry_total;

endmodule
